// ===== rtl/core/spe_pkg.sv =====
package spe_pkg;

  localparam int ACC_W       = 64;
  localparam int RCOEF_W     = 40;
  localparam int MAX_RESULTS = 64;

  localparam logic signed [ACC_W-1:0] ACC_LIM  = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] RC_MAX   = 64'sd549755813887;
  localparam logic signed [ACC_W-1:0] RC_MIN   = -64'sd549755813888;

  typedef enum logic [2:0] {
    CMD_LOAD_A = 3'd0,
    CMD_LOAD_B = 3'd1,
    CMD_ADD    = 3'd2,
    CMD_SUB    = 3'd3,
    CMD_MUL    = 3'd4,
    CMD_DERIV  = 3'd5
  } cmd_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

  function automatic logic signed [ACC_W-1:0] clamp_acc(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > ACC_LIM) r = ACC_LIM;
    else if (v < -ACC_LIM) r = -ACC_LIM;
    else r = v;
    return r;
  endfunction

  function automatic logic signed [RCOEF_W-1:0] sat_rcoef(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > RC_MAX) r = RC_MAX;
    else if (v < RC_MIN) r = RC_MIN;
    else r = v;
    return r[RCOEF_W-1:0];
  endfunction

endpackage

// ===== rtl/core/sparse_polynomial_engine_core.sv =====
// channel  | dir | tdata                                  | tuser                  | tlast
// s_axis   | in  | coefficient, exponent                  | command[2:0], restart  | -
// m_axis   | out | result_coefficient[39:0], result_exp   | zero_result            | last_term
//
// a load writes its term into table A or B; an operation runs its term generation (a product,
// a sum or a derivative), then a drain while the done flag and the sorting cell chain settle,
// then shifts the stored terms out through cell zero, and closes with a final transfer
// rst clears the term counts, the cell valid bits and the output valid; the input comes up ready
// a stalled output holds the chain but for zero head terms; input is taken only between operations
module sparse_polynomial_engine_core
  import spe_pkg::*;
#(
  parameter int MAX_TERMS = 8,
  parameter int COEF_BITS = 16,
  parameter int EXP_BITS  = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [((COEF_BITS+EXP_BITS+7)/8)*8-1:0] s_axis_tdata,  // coefficient, exponent
  input  logic [3:0]     s_axis_tuser,                           // command, restart
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [((RCOEF_W+EXP_BITS+1+7)/8)*8-1:0] m_axis_tdata,  // result_coefficient, result_exponent
  output logic           m_axis_tlast,
  output logic           m_axis_tuser                            // zero_result
);

  localparam int WORK_DEPTH = MAX_TERMS * MAX_TERMS;
  localparam int RE         = EXP_BITS + 1;
  localparam int ODW        = ((RCOEF_W + RE + 7) / 8) * 8;
  localparam int DW         = $clog2(WORK_DEPTH + 4);
  localparam int NW         = $clog2(MAX_RESULTS + 1);
  localparam logic [DW-1:0] DRAIN_LEN = DW'(WORK_DEPTH + 3);
  localparam logic [NW-1:0] N_LASTIDX = NW'(MAX_RESULTS - 1);

  typedef enum logic [1:0] {S_IDLE, S_GEN, S_DRAIN, S_OUT} state_t;

  state_t     state;
  cell_ctrl_t ctrl;
  cmd_t       cmd;

  logic                    accept;
  logic                    is_load;
  logic                    is_op;
  logic                    tg_valid;
  logic [RE-1:0]           tg_exp;
  logic signed [ACC_W-1:0] tg_coef;
  logic                    gen_done;

  logic                    st_valid [WORK_DEPTH];
  logic [RE-1:0]           st_exp   [WORK_DEPTH];
  logic signed [ACC_W-1:0] st_coef  [WORK_DEPTH];
  logic                    ps_valid [WORK_DEPTH];
  logic [RE-1:0]           ps_exp   [WORK_DEPTH];
  logic signed [ACC_W-1:0] ps_coef  [WORK_DEPTH];

  logic [DW-1:0]           drain_cnt;
  logic                    pend_valid;
  logic [RE-1:0]           pend_exp;
  logic signed [ACC_W-1:0] pend_coef;
  logic [NW-1:0]           n_emit;
  logic                    out_free;
  logic                    head_valid;
  logic                    head_zero;

  assign cmd           = cmd_t'(s_axis_tuser[2:0]);
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_load       = (cmd == CMD_LOAD_A) || (cmd == CMD_LOAD_B);
  assign is_op         = (cmd == CMD_ADD) || (cmd == CMD_SUB) || (cmd == CMD_MUL) ||
                         (cmd == CMD_DERIV);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign head_valid    = st_valid[0];
  assign head_zero     = (st_coef[0] == '0);

  assign ctrl.clear = accept && is_op;
  assign ctrl.shift = (state == S_OUT) && head_valid && (head_zero || !pend_valid || out_free);

  spe_termgen #(
    .MAX_TERMS (MAX_TERMS),
    .COEF_BITS (COEF_BITS),
    .EXP_BITS  (EXP_BITS)
  ) u_termgen (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (accept && is_load),
    .load_b      (cmd == CMD_LOAD_B),
    .restart     (s_axis_tuser[3]),
    .coefficient (s_axis_tdata[COEF_BITS-1:0]),
    .exponent    (s_axis_tdata[COEF_BITS +: EXP_BITS]),
    .start       (accept && is_op),
    .start_cmd   (cmd),
    .t_valid     (tg_valid),
    .t_exp       (tg_exp),
    .t_coef      (tg_coef),
    .gen_done    (gen_done)
  );

  for (genvar k = 0; k < WORK_DEPTH; k++) begin : g_cell
    logic                    in_v;
    logic [RE-1:0]           in_e;
    logic signed [ACC_W-1:0] in_c;
    logic                    nb_v;
    logic [RE-1:0]           nb_e;
    logic signed [ACC_W-1:0] nb_c;
    if (k == 0) begin : g_first
      assign in_v = tg_valid;
      assign in_e = tg_exp;
      assign in_c = tg_coef;
    end else begin : g_mid
      assign in_v = ps_valid[k-1];
      assign in_e = ps_exp[k-1];
      assign in_c = ps_coef[k-1];
    end
    if (k == WORK_DEPTH - 1) begin : g_end
      assign nb_v = 1'b0;
      assign nb_e = '0;
      assign nb_c = '0;
    end else begin : g_inner
      assign nb_v = st_valid[k+1];
      assign nb_e = st_exp[k+1];
      assign nb_c = st_coef[k+1];
    end
    spe_cell #(.EXP_W(RE)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .in_valid   (in_v),
      .in_exp     (in_e),
      .in_coef    (in_c),
      .nb_valid   (nb_v),
      .nb_exp     (nb_e),
      .nb_coef    (nb_c),
      .st_valid   (st_valid[k]),
      .st_exp     (st_exp[k]),
      .st_coef    (st_coef[k]),
      .pass_valid (ps_valid[k]),
      .pass_exp   (ps_exp[k]),
      .pass_coef  (ps_coef[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pend_valid    <= 1'b0;
      n_emit        <= '0;
      m_axis_tvalid <= 1'b0;
      drain_cnt     <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && is_op) begin
            state      <= S_GEN;
            pend_valid <= 1'b0;
            n_emit     <= '0;
          end
        end
        S_GEN: begin
          if (gen_done) begin
            state     <= S_DRAIN;
            drain_cnt <= DRAIN_LEN;
          end
        end
        S_DRAIN: begin
          if (drain_cnt == '0) state <= S_OUT;
          else drain_cnt <= drain_cnt - 1'b1;
        end
        S_OUT: begin
          if (!head_valid) begin
            if (out_free) begin
              m_axis_tvalid <= 1'b1;
              m_axis_tlast  <= 1'b1;
              m_axis_tuser  <= !pend_valid;
              m_axis_tdata  <= pend_valid ?
                               ODW'({pend_exp, sat_rcoef(pend_coef)}) : '0;
              pend_valid    <= 1'b0;
              state         <= S_IDLE;
            end
          end else if (!head_zero) begin
            if (!pend_valid) begin
              pend_valid <= 1'b1;
              pend_exp   <= st_exp[0];
              pend_coef  <= st_coef[0];
            end else if (out_free) begin
              m_axis_tvalid <= 1'b1;
              m_axis_tuser  <= 1'b0;
              m_axis_tdata  <= ODW'({pend_exp, sat_rcoef(pend_coef)});
              n_emit        <= n_emit + 1'b1;
              pend_exp      <= st_exp[0];
              pend_coef     <= st_coef[0];
              if (n_emit == N_LASTIDX) begin
                m_axis_tlast <= 1'b1;
                pend_valid   <= 1'b0;
                state        <= S_IDLE;
              end else begin
                m_axis_tlast <= 1'b0;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_shift_during_insert: assert property (@(posedge clk) disable iff (rst)
    ctrl.shift |-> !tg_valid)
    else $error("chain shift while a term enters");
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("pending term left after operation");
  a_zero_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("zero result not marked last");
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    n_emit <= NW'(MAX_RESULTS))
    else $error("too many result transfers");
  a_no_input_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN || state == S_OUT) |-> !s_axis_tready)
    else $error("input taken during operation");
`endif

endmodule

// ===== rtl/core/spe_cell.sv =====
module spe_cell
  import spe_pkg::*;
#(
  parameter int EXP_W = 9
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cell_ctrl_t              ctrl,
  input  logic                    in_valid,
  input  logic [EXP_W-1:0]        in_exp,
  input  logic signed [ACC_W-1:0] in_coef,
  input  logic                    nb_valid,
  input  logic [EXP_W-1:0]        nb_exp,
  input  logic signed [ACC_W-1:0] nb_coef,
  output logic                    st_valid,
  output logic [EXP_W-1:0]        st_exp,
  output logic signed [ACC_W-1:0] st_coef,
  output logic                    pass_valid,
  output logic [EXP_W-1:0]        pass_exp,
  output logic signed [ACC_W-1:0] pass_coef
);

  logic                    valid;
  logic [EXP_W-1:0]        exp_q;
  logic signed [ACC_W-1:0] coef;
  logic                    pv;
  logic [EXP_W-1:0]        pexp;
  logic signed [ACC_W-1:0] pcoef;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      pv    <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
      pv    <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= nb_valid;
      exp_q <= nb_exp;
      coef  <= nb_coef;
      pv    <= 1'b0;
    end else begin
      pv <= 1'b0;
      if (in_valid) begin
        if (!valid) begin
          valid <= 1'b1;
          exp_q <= in_exp;
          coef  <= in_coef;
        end else if (in_exp < exp_q) begin
          exp_q <= in_exp;
          coef  <= in_coef;
          pv    <= 1'b1;
          pexp  <= exp_q;
          pcoef <= coef;
        end else if (in_exp == exp_q) begin
          coef <= clamp_acc(coef + in_coef);
        end else begin
          pv    <= 1'b1;
          pexp  <= in_exp;
          pcoef <= in_coef;
        end
      end
    end
  end

  assign st_valid   = valid;
  assign st_exp     = exp_q;
  assign st_coef    = coef;
  assign pass_valid = pv;
  assign pass_exp   = pexp;
  assign pass_coef  = pcoef;

endmodule

// ===== rtl/core/spe_termgen.sv =====
module spe_termgen
  import spe_pkg::*;
#(
  parameter int MAX_TERMS = 8,
  parameter int COEF_BITS = 16,
  parameter int EXP_BITS  = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load_valid,
  input  logic                       load_b,
  input  logic                       restart,
  input  logic signed [COEF_BITS-1:0] coefficient,
  input  logic [EXP_BITS-1:0]        exponent,
  input  logic                       start,
  input  cmd_t                       start_cmd,
  output logic                       t_valid,
  output logic [EXP_BITS:0]          t_exp,
  output logic signed [ACC_W-1:0]    t_coef,
  output logic                       gen_done
);

  localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TERMS);

  typedef enum logic {G_IDLE, G_RUN} gstate_t;

  logic signed [COEF_BITS-1:0] a_coef [MAX_TERMS];
  logic [EXP_BITS-1:0]         a_exp  [MAX_TERMS];
  logic signed [COEF_BITS-1:0] b_coef [MAX_TERMS];
  logic [EXP_BITS-1:0]         b_exp  [MAX_TERMS];
  logic [CW-1:0]               a_cnt;
  logic [CW-1:0]               b_cnt;
  logic [CW-1:0]               ld_base;

  gstate_t       state;
  cmd_t          op;
  logic          phase;
  logic [CW-1:0] gi;
  logic [CW-1:0] gj;

  logic                    s1_valid;
  logic [EXP_BITS:0]       s1_exp;
  logic signed [ACC_W-1:0] s1_coef;

  logic signed [COEF_BITS-1:0]         ra;
  logic [EXP_BITS-1:0]                 rae;
  logic signed [COEF_BITS-1:0]         rb;
  logic [EXP_BITS-1:0]                 rbe;
  logic [IW-1:0]                       b_idx;
  logic signed [2*COEF_BITS-1:0]       mprod;
  logic signed [COEF_BITS+EXP_BITS:0]  dprod;

  assign ld_base = restart ? '0 : (load_b ? b_cnt : a_cnt);
  assign b_idx   = (op == CMD_MUL) ? gj[IW-1:0] : gi[IW-1:0];
  assign ra      = a_coef[gi[IW-1:0]];
  assign rae     = a_exp[gi[IW-1:0]];
  assign rb      = b_coef[b_idx];
  assign rbe     = b_exp[b_idx];
  assign mprod   = ra * rb;
  assign dprod   = ra * $signed({1'b0, rae});

  always_ff @(posedge clk) begin
    if (load_valid && ld_base < MAX_CNT) begin
      if (load_b) begin
        b_coef[ld_base[IW-1:0]] <= coefficient;
        b_exp[ld_base[IW-1:0]]  <= exponent;
      end else begin
        a_coef[ld_base[IW-1:0]] <= coefficient;
        a_exp[ld_base[IW-1:0]]  <= exponent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_cnt    <= '0;
      b_cnt    <= '0;
      state    <= G_IDLE;
      s1_valid <= 1'b0;
      t_valid  <= 1'b0;
      gen_done <= 1'b0;
    end else begin
      s1_valid <= 1'b0;
      gen_done <= 1'b0;
      t_valid  <= s1_valid;
      t_exp    <= s1_exp;
      t_coef   <= clamp_acc(s1_coef);
      if (load_valid) begin
        if (load_b) b_cnt <= (ld_base < MAX_CNT) ? ld_base + 1'b1 : ld_base;
        else        a_cnt <= (ld_base < MAX_CNT) ? ld_base + 1'b1 : ld_base;
      end
      if (start) begin
        state <= G_RUN;
        op    <= start_cmd;
        phase <= 1'b0;
        gi    <= '0;
        gj    <= '0;
      end else if (state == G_RUN) begin
        unique case (op) inside
          CMD_ADD, CMD_SUB: begin
            if (!phase) begin
              if (gi < a_cnt) begin
                s1_valid <= 1'b1;
                s1_exp   <= {1'b0, rae};
                s1_coef  <= ACC_W'(ra);
                gi       <= gi + 1'b1;
              end else begin
                phase <= 1'b1;
                gi    <= '0;
              end
            end else if (gi < b_cnt) begin
              s1_valid <= 1'b1;
              s1_exp   <= {1'b0, rbe};
              s1_coef  <= (op == CMD_ADD) ? ACC_W'(rb) : -ACC_W'(rb);
              gi       <= gi + 1'b1;
            end else begin
              state    <= G_IDLE;
              gen_done <= 1'b1;
            end
          end
          CMD_MUL: begin
            if (gi >= a_cnt) begin
              state    <= G_IDLE;
              gen_done <= 1'b1;
            end else if (gj < b_cnt) begin
              s1_valid <= 1'b1;
              s1_exp   <= {1'b0, rae} + {1'b0, rbe};
              s1_coef  <= ACC_W'(mprod);
              gj       <= gj + 1'b1;
            end else begin
              gj <= '0;
              gi <= gi + 1'b1;
            end
          end
          CMD_DERIV: begin
            if (gi < a_cnt) begin
              s1_valid <= (rae != '0);
              s1_exp   <= {1'b0, rae} - 1'b1;
              s1_coef  <= ACC_W'(dprod);
              gi       <= gi + 1'b1;
            end else begin
              state    <= G_IDLE;
              gen_done <= 1'b1;
            end
          end
          default: begin
            state    <= G_IDLE;
            gen_done <= 1'b1;
          end
        endcase
      end
    end
  end

endmodule
